// ----- rtl/dta_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dta_pkg: shared types and microcode for the decimal to ASCII formatter
// Holds the number constants, the control word layout and the program ROM
// that the sequencer steps through.
// ----------------------------------------------------------------------------
package dta_pkg;

	localparam int DIGITS        = 29;
	localparam int MANTISSA_BITS = 96;
	localparam int BCD_BITS      = DIGITS * 4;
	localparam int BCNT_W        = $clog2(MANTISSA_BITS);
	localparam int DCNT_W        = $clog2(DIGITS);

	localparam logic [4:0] MAX_SCALE = 5'd28;

	localparam logic [5:0] CH_ZERO  = 6'd48;
	localparam logic [5:0] CH_MINUS = 6'd45;
	localparam logic [5:0] CH_POINT = 6'd46;

	typedef logic [2:0] step_t;

	localparam step_t STEP_IDLE  = 3'd0;
	localparam step_t STEP_SIGN  = 3'd1;
	localparam step_t STEP_SHIFT = 3'd2;
	localparam step_t STEP_DIGIT = 3'd3;
	localparam step_t STEP_POINT = 3'd4;

	// datapath operations
	typedef enum logic [2:0] {
		OP_LOAD  = 3'd0,
		OP_SIGN  = 3'd1,
		OP_SHIFT = 3'd2,
		OP_DIGIT = 3'd3,
		OP_POINT = 3'd4
	} op_t;

	// jump conditions
	typedef enum logic [2:0] {
		COND_NEVER      = 3'd0,
		COND_ALWAYS     = 3'd1,
		COND_NOT_START  = 3'd2,
		COND_BITS_LEFT  = 3'd3,
		COND_LAST_DIGIT = 3'd4,
		COND_NO_POINT   = 3'd5
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond_a;
		step_t target_a;
		cond_t cond_b;
		step_t target_b;
	} ctrl_word_t;

	typedef struct packed {
		logic bits_left;
		logic last_digit;
		logic point_due;
	} dp_status_t;

	// program: jump A has priority over jump B, otherwise fall through
	function automatic ctrl_word_t ucode(input step_t s);
		ctrl_word_t w;
		unique case (s)
			STEP_IDLE:  w = '{OP_LOAD,  COND_NOT_START,  STEP_IDLE,  COND_NEVER,    STEP_IDLE};
			STEP_SIGN:  w = '{OP_SIGN,  COND_NEVER,      STEP_IDLE,  COND_NEVER,    STEP_IDLE};
			STEP_SHIFT: w = '{OP_SHIFT, COND_BITS_LEFT,  STEP_SHIFT, COND_NEVER,    STEP_IDLE};
			STEP_DIGIT: w = '{OP_DIGIT, COND_LAST_DIGIT, STEP_IDLE,  COND_NO_POINT, STEP_DIGIT};
			STEP_POINT: w = '{OP_POINT, COND_ALWAYS,     STEP_DIGIT, COND_NEVER,    STEP_IDLE};
			default:    w = '{OP_LOAD,  COND_ALWAYS,     STEP_IDLE,  COND_NEVER,    STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

// ----- rtl/dta_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dta_sequencer: microcode step counter
// Reads one control word per step from the program ROM and picks the next
// step from two prioritized conditional jumps.
// ----------------------------------------------------------------------------
module dta_sequencer
	import dta_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  dp_status_t status,
	output ctrl_word_t ctrl,
	output logic       busy
);

	step_t step_q;
	step_t step_next;
	logic  take_a;
	logic  take_b;

	function automatic logic eval_cond(input cond_t c, input logic st, input dp_status_t s);
		logic r;
		unique case (c)
			COND_NEVER:      r = 1'b0;
			COND_ALWAYS:     r = 1'b1;
			COND_NOT_START:  r = !st;
			COND_BITS_LEFT:  r = s.bits_left;
			COND_LAST_DIGIT: r = s.last_digit;
			COND_NO_POINT:   r = !s.point_due;
			default:         r = 1'b0;
		endcase
		return r;
	endfunction

	// decode the current step
	assign ctrl   = ucode(step_q);
	assign busy   = (step_q != STEP_IDLE);
	assign take_a = eval_cond(ctrl.cond_a, start, status);
	assign take_b = eval_cond(ctrl.cond_b, start, status);

	// pick the next step
	always_comb begin
		if (take_a) begin
			step_next = ctrl.target_a;
		end else if (take_b) begin
			step_next = ctrl.target_b;
		end else begin
			step_next = step_q + 3'd1;
		end
	end

	// advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else begin
			step_q <= step_next;
		end
	end

endmodule

// ----- rtl/dta_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dta_datapath: shift-and-add-3 converter and character output register
// Turns the mantissa into BCD one bit per shift step, then hands out one
// digit per digit step with leading zero suppression.
// ----------------------------------------------------------------------------
module dta_datapath
	import dta_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  ctrl_word_t               ctrl,
	input  logic [MANTISSA_BITS-1:0] mantissa,
	input  logic                     negative,
	input  logic [4:0]               scale,
	output dp_status_t               status,
	output logic [5:0]               character,
	output logic                     last,
	output logic                     strobe
);

	logic [MANTISSA_BITS-1:0] mant_q;
	logic [BCD_BITS-1:0]      bcd_q;
	logic [BCD_BITS-1:0]      bcd_adj;
	logic [4:0]               sc_q;
	logic                     neg_q;
	logic [BCNT_W-1:0]        bcnt_q;
	logic [DCNT_W-1:0]        dcnt_q;
	logic                     started_q;
	logic [5:0]               char_q;
	logic                     last_q;
	logic                     strobe_q;
	logic [3:0]               top_digit;
	logic                     show_digit;

	// add 3 to every digit of five or more before the shift
	always_comb begin
		bcd_adj = bcd_q;
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end
		end
	end

	assign top_digit  = bcd_q[BCD_BITS-1 -: 4];
	assign show_digit = started_q || (top_digit != 4'd0) || (dcnt_q == sc_q);

	assign status.bits_left  = (bcnt_q != '0);
	assign status.last_digit = (dcnt_q == '0);
	assign status.point_due  = (dcnt_q == sc_q) && (sc_q != 5'd0);

	// load, convert and shift out digits
	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_LOAD: begin
				if (start) begin
					mant_q <= mantissa;
					bcd_q  <= '0;
					neg_q  <= negative;
					sc_q   <= (scale > MAX_SCALE) ? 5'd0 : scale;
					bcnt_q <= BCNT_W'(MANTISSA_BITS - 1);
					dcnt_q <= DCNT_W'(DIGITS - 1);
				end
			end
			OP_SHIFT: begin
				bcd_q  <= {bcd_adj[BCD_BITS-2:0], mant_q[MANTISSA_BITS-1]};
				mant_q <= {mant_q[MANTISSA_BITS-2:0], 1'b0};
				bcnt_q <= bcnt_q - BCNT_W'(1);
			end
			OP_DIGIT: begin
				bcd_q  <= {bcd_q[BCD_BITS-5:0], 4'd0};
				dcnt_q <= dcnt_q - DCNT_W'(1);
			end
			default: begin
			end
		endcase
	end

	// pick the character for this step
	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_SIGN:  char_q <= CH_MINUS;
			OP_DIGIT: char_q <= CH_ZERO + {2'b00, top_digit};
			OP_POINT: char_q <= CH_POINT;
			default:  char_q <= char_q;
		endcase
	end

	// drive the strobe, last marker and zero suppression flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			strobe_q  <= 1'b0;
			last_q    <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
			case (ctrl.op)
				OP_LOAD: begin
					started_q <= 1'b0;
				end
				OP_SIGN: begin
					strobe_q <= neg_q;
				end
				OP_DIGIT: begin
					started_q <= show_digit;
					strobe_q  <= show_digit;
					last_q    <= (dcnt_q == '0);
				end
				OP_POINT: begin
					strobe_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign character = char_q;
	assign last      = last_q;
	assign strobe    = strobe_q;

endmodule

// ----- rtl/decimal_to_ascii_string.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_to_ascii_string: 96-bit decimal number to ASCII text
// Microcoded formatter: a sequencer steps a shift-and-add-3 BCD converter
// and a character output register.
// ----------------------------------------------------------------------------
// A number is taken when start is high and busy is low. Its text comes out
// as one word per strobe cycle: a minus when negative is set, the digits
// with leading zeros dropped down to the digit at the scale position, and a
// point after that digit when scale is nonzero (scale above 28 counts as 0).
// last marks the units digit, which always ends the text. The receiver
// cannot stall, and words may have idle gaps where leading zeros are
// dropped and while the converter runs. From accept until busy falls, one
// number takes one sign step, 96 shift steps of the converter (one mantissa
// bit each), 29 digit steps and, with a point, the point step. Each word is
// registered and leaves in the cycle after its step, so the last word shows
// in the first cycle busy is low, and the next number can be taken in that
// cycle.
// ----------------------------------------------------------------------------
module decimal_to_ascii_string
	import dta_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] mantissa_low,
	input  logic [31:0] mantissa_mid,
	input  logic [31:0] mantissa_high,
	input  logic        negative,
	input  logic [4:0]  scale,
	output logic        strobe,
	output logic [5:0]  character,
	output logic        last
);

	ctrl_word_t ctrl;
	dp_status_t status;

	dta_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	dta_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.ctrl      (ctrl),
		.mantissa  ({mantissa_high, mantissa_mid, mantissa_low}),
		.negative  (negative),
		.scale     (scale),
		.status    (status),
		.character (character),
		.last      (last),
		.strobe    (strobe)
	);

	// a word leaves only for a number under way
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("strobe without a number in progress");

	// the last marker rides on a word
	a_last_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> strobe)
		else $error("last without strobe");

	// an accepted number holds the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accept did not raise busy");

	// nothing follows the last word directly
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		last |=> !strobe)
		else $error("word right after last");

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the decimal to ASCII formatter
// A queue of numbers, first hand-picked corner cases and then random ones,
// feeds a start/busy driver. Every accepted number is run through a local
// model that writes the expected characters into a queue. The monitor pops
// one expected word per strobe and compares character and last.
// ----------------------------------------------------------------------------
module tb_top;
	import dta_pkg::*;

	localparam int RANDOM_NUMBERS = 300;
	localparam int CALM_TAIL      = 40;
	localparam int DRAIN_CYCLES   = 140;
	localparam int LIMIT_CYCLES   = 400000;

	typedef struct packed {
		logic [31:0] low;
		logic [31:0] mid;
		logic [31:0] high;
		logic        neg;
		logic [4:0]  scale;
	} number_t;

	typedef struct packed {
		logic [5:0] ch;
		logic       last;
	} text_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [31:0] mantissa_low = '0;
	logic [31:0] mantissa_mid = '0;
	logic [31:0] mantissa_high = '0;
	logic        negative = 1'b0;
	logic [4:0]  scale = '0;
	logic        strobe;
	logic [5:0]  character;
	logic        last;

	number_t     number_q[$];
	text_word_t  text_q[$];
	int          err_count = 0;
	int          cycle_count = 0;
	int          issued = 0;
	int          total_numbers = 0;
	int          gap_left = 0;
	logic        number_taken = 1'b0;

	decimal_to_ascii_string i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.mantissa_low  (mantissa_low),
		.mantissa_mid  (mantissa_mid),
		.mantissa_high (mantissa_high),
		.negative      (negative),
		.scale         (scale),
		.strobe        (strobe),
		.character     (character),
		.last          (last)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
		err_count++;
	endtask

	// Format one number into its expected character words
	task automatic predict_text(input number_t n);
		logic [95:0] m;
		logic [3:0]  dig [DIGITS];
		int          sc;
		bit          started;
		text_word_t  w;
		m = {n.high, n.mid, n.low};
		for (int d = 0; d < DIGITS; d++) begin
			dig[d] = 4'(m % 96'd10);
			m = m / 96'd10;
		end
		// out-of-range scale counts as no fraction
		sc = (n.scale > MAX_SCALE) ? 0 : int'(n.scale);
		started = 1'b0;
		if (n.neg) begin
			w.ch = CH_MINUS;
			w.last = 1'b0;
			text_q.push_back(w);
		end
		for (int j = DIGITS - 1; j >= 0; j--) begin
			if (started || dig[j] != 4'd0 || j == sc) begin
				started = 1'b1;
				// the units digit always closes the text
				w.ch = CH_ZERO + 6'(dig[j]);
				w.last = (j == 0);
				text_q.push_back(w);
				if (j == sc && j != 0) begin
					w.ch = CH_POINT;
					w.last = 1'b0;
					text_q.push_back(w);
				end
			end
		end
	endtask

	task automatic add_number(input logic [31:0] lo, input logic [31:0] mi,
		input logic [31:0] hi, input logic ng, input logic [4:0] sc);
		number_t n;
		n.low = lo;
		n.mid = mi;
		n.high = hi;
		n.neg = ng;
		n.scale = sc;
		number_q.push_back(n);
	endtask

	// Driver: present the next number at the falling edge, hold it until taken
	always @(negedge clk) begin
		number_t n;
		if (arst_n) begin
			if (start && !number_taken) begin
				// hold the current number
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
				mantissa_low <= $urandom;
				mantissa_mid <= $urandom;
				mantissa_high <= $urandom;
				negative <= 1'($urandom);
				scale <= 5'($urandom);
			end else if (number_q.size() != 0 &&
				(issued >= total_numbers - CALM_TAIL || $urandom_range(0, 3) != 0)) begin
				n = number_q.pop_front();
				issued <= issued + 1;
				start <= 1'b1;
				mantissa_low <= n.low;
				mantissa_mid <= n.mid;
				mantissa_high <= n.high;
				negative <= n.neg;
				scale <= n.scale;
			end else begin
				// drop start for a random burst, drive noise on the fields
				if (number_q.size() != 0) begin
					gap_left <= $urandom_range(1, 5) - 1;
				end
				start <= 1'b0;
				mantissa_low <= $urandom;
				mantissa_mid <= $urandom;
				mantissa_high <= $urandom;
				negative <= 1'($urandom);
				scale <= 5'($urandom);
			end
		end
	end

	// Monitor: predict on accept, check each strobed word, watch the limit
	always @(posedge clk) begin
		number_t    n;
		text_word_t w;
		cycle_count <= cycle_count + 1;
		number_taken <= arst_n && start && !busy;
		if (arst_n && start && !busy) begin
			n.low = mantissa_low;
			n.mid = mantissa_mid;
			n.high = mantissa_high;
			n.neg = negative;
			n.scale = scale;
			predict_text(n);
		end
		if (arst_n && strobe) begin
			if (text_q.size() == 0) begin
				report_mismatch($sformatf("unexpected word char=%0d last=%0b",
					character, last));
			end else begin
				w = text_q.pop_front();
				if (character !== w.ch) begin
					report_mismatch($sformatf("character got %0d want %0d",
						character, w.ch));
				end
				if (last !== w.last) begin
					report_mismatch($sformatf("last got %0b want %0b (char %0d)",
						last, w.last, w.ch));
				end
			end
		end
		if (cycle_count > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		logic [95:0] m;
		logic [4:0]  sc;
		// corner cases: zero, negative zero, full mantissa, every scale edge
		add_number(32'd0, 32'd0, 32'd0, 1'b0, 5'd0);
		add_number(32'd0, 32'd0, 32'd0, 1'b1, 5'd0);
		add_number(32'd0, 32'd0, 32'd0, 1'b1, 5'd2);
		add_number(32'd0, 32'd0, 32'd0, 1'b0, 5'd28);
		add_number('1, '1, '1, 1'b0, 5'd0);
		add_number('1, '1, '1, 1'b1, 5'd0);
		add_number('1, '1, '1, 1'b0, 5'd28);
		add_number('1, '1, '1, 1'b1, 5'd28);
		add_number(32'd1, 32'd0, 32'd0, 1'b0, 5'd28);
		add_number(32'd1, 32'd0, 32'd0, 1'b1, 5'd0);
		add_number(32'd5, 32'd0, 32'd0, 1'b0, 5'd1);
		add_number(32'd12345, 32'd0, 32'd0, 1'b1, 5'd5);
		add_number(32'd12345, 32'd0, 32'd0, 1'b0, 5'd4);
		add_number(32'd987654321, 32'd0, 32'd0, 1'b0, 5'd29);
		add_number('1, '1, '1, 1'b1, 5'd30);
		add_number(32'd0, 32'd0, 32'd0, 1'b1, 5'd31);
		add_number(32'd0, 32'd0, 32'h8000_0000, 1'b0, 5'd27);
		add_number('1, 32'd0, 32'd0, 1'b0, 5'd10);
		add_number(32'd0, '1, 32'd0, 1'b1, 5'd19);
		add_number(32'd9, 32'd0, 32'd0, 1'b0, 5'd1);
		add_number(32'd10, 32'd0, 32'd0, 1'b0, 5'd0);
		// random numbers spread over all magnitudes
		for (int i = 0; i < RANDOM_NUMBERS; i++) begin
			case ($urandom_range(0, 4))
				0: m = 96'($urandom_range(0, 999));
				1: m = {64'd0, 32'($urandom)};
				2: m = {32'd0, 32'($urandom), 32'($urandom)};
				3: m = {32'($urandom), 32'($urandom), 32'($urandom)};
				default: m = {32'($urandom), 32'($urandom), 32'($urandom)} >>
					$urandom_range(0, 95);
			endcase
			sc = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(29, 31)) :
				5'($urandom_range(0, 28));
			add_number(m[31:0], m[63:32], m[95:64], 1'($urandom), sc);
		end
		total_numbers = number_q.size();
		// hold reset, then release away from the active edge
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// wait for the stimulus to drain and every word to arrive
		while (number_q.size() != 0 || start || busy || text_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (text_q.size() != 0) begin
			report_mismatch($sformatf("%0d words never arrived", text_q.size()));
		end
		if (err_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/dta_pkg.sv
rtl/dta_sequencer.sv
rtl/dta_datapath.sv
rtl/decimal_to_ascii_string.sv
tb/sv/tb_top.sv
